/* hdl/polyev_pkg.sv */
// shared types and constants of the polynomial evaluator
package polyev_pkg;

	localparam int Q_W       = 32;
	localparam int FRAC_BITS = 16;
	localparam int NUM_COEFS = 8;
	localparam int IDX_W     = $clog2(NUM_COEFS);
	localparam int IDX_LSB   = 2;
	localparam int ADDR_W    = IDX_W + IDX_LSB;
	localparam int PROD_W    = 2 * Q_W;

	typedef logic signed [Q_W-1:0] q_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef q_t [NUM_COEFS-1:0] coef_arr_t;

	localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	// data handed from one cell to the next
	typedef struct packed {
		logic valid;
		q_t   x;
		q_t   acc;
		logic ovf;
	} cell_data_t;

	// one result item
	typedef struct packed {
		q_t   value;
		logic overflow;
	} res_t;

endpackage

/* hdl/polyev_if.sv */
// stream interfaces for evaluation points and results
interface polyev_point_if;
	logic           valid;
	logic           ready;
	polyev_pkg::q_t point;

	modport source (output valid, output point, input ready);
	modport sink (input valid, input point, output ready);
endinterface

interface polyev_result_if;
	logic           valid;
	logic           ready;
	polyev_pkg::q_t value;
	logic           overflow;

	modport source (output valid, output value, output overflow, input ready);
	modport sink (input valid, input value, input overflow, output ready);
endinterface

/* hdl/polyev_regs.sv */
// apb coefficient register file
module polyev_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [polyev_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output polyev_pkg::coef_arr_t         coefs
);
	import polyev_pkg::*;

	coef_arr_t        coef_q;
	logic [IDX_W-1:0] idx;
	logic             wr;

	assign idx    = paddr[ADDR_W-1:IDX_LSB];
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr) begin
			coef_q[idx] <= q_t'(pwdata);
		end
	end

	assign prdata = 32'(coef_q[idx]);
	assign coefs  = coef_q;

endmodule

/* hdl/polyev_cell.sv */
// one horner step: multiply stage, then shift, saturate and add stage
module polyev_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  polyev_pkg::q_t         coef,
	input  polyev_pkg::cell_data_t cin,
	output polyev_pkg::cell_data_t cout
);
	import polyev_pkg::*;

	logic                  valid_s1;
	q_t                    x_s1;
	logic                  ovf_s1;
	prod_t                 prod_s1;
	prod_t                 shifted;
	logic [PROD_W-Q_W:0]   prod_hi;
	logic                  p_ovf;
	q_t                    scaled;
	logic signed [Q_W:0]   sum;
	logic                  s_ovf;
	q_t                    acc_c;
	logic                  valid_s2;
	q_t                    x_s2;
	q_t                    acc_s2;
	logic                  ovf_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cin.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= cin.x;
			ovf_s1  <= cin.ovf;
			prod_s1 <= prod_t'(cin.acc) * prod_t'(cin.x);
		end
	end

	// floor shift, then clamp the product to 32 bits
	assign shifted = prod_s1 >>> FRAC_BITS;
	assign prod_hi = shifted[PROD_W-1:Q_W-1];
	assign p_ovf   = (|prod_hi) && !(&prod_hi);
	assign scaled  = p_ovf ? (shifted[PROD_W-1] ? Q_MIN : Q_MAX) : shifted[Q_W-1:0];

	assign sum   = (Q_W+1)'(scaled) + (Q_W+1)'(coef);
	assign s_ovf = sum[Q_W] ^ sum[Q_W-1];
	assign acc_c = s_ovf ? (sum[Q_W] ? Q_MIN : Q_MAX) : sum[Q_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2   <= x_s1;
			acc_s2 <= acc_c;
			ovf_s2 <= ovf_s1 || p_ovf || s_ovf;
		end
	end

	assign cout = '{valid: valid_s2, x: x_s2, acc: acc_s2, ovf: ovf_s2};

endmodule

/* hdl/polyev_outbuf.sv */
// output register with skid entry
module polyev_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  polyev_pkg::res_t item,
	output logic             en,
	output logic             out_valid,
	output polyev_pkg::res_t out_item,
	input  logic             out_ready
);
	import polyev_pkg::*;

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic pop;
	logic push;

	assign en   = !skid_valid_q;
	assign pop  = main_valid_q && out_ready;
	assign push = item_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= item;
			end else begin
				main_q <= item;
			end
		end
	end

	assign out_valid = main_valid_q;
	assign out_item  = main_q;

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without a main entry");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(main_valid_q && !out_ready && !skid_valid_q && item_valid) |=> skid_valid_q)
		else $error("stalled result not caught by skid entry");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_ready) |=> (main_valid_q && !skid_valid_q))
		else $error("skid entry not moved to main entry");

endmodule

/* hdl/polynomial_evaluator.sv */
// top level: apb coefficients, chain of horner cells, output buffer
//
//   channel   dir  handshake        payload
//   points    in   valid / ready    point (signed q16.16)
//   results   out  valid / ready    value (signed q16.16), overflow
//   apb       in   psel / penable   paddr, pwdata, prdata, pready
//
// one point enters per cycle while the chain is not held; a point passes both
// stages of every cell and then the output register
// each cell holds one multiply stage and one shift/saturate/add stage
// reset clears the coefficients and all valid flags, no clearing pass
// when the result side stalls, the skid entry catches the item in flight
// and the whole cell chain then holds until the skid entry drains
module polynomial_evaluator #(
	parameter int MAX_DEGREE = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	polyev_point_if.sink                  points,
	polyev_result_if.source               results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [polyev_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import polyev_pkg::*;

	coef_arr_t  coefs;
	cell_data_t chain [MAX_DEGREE+1];
	logic       en;
	res_t       tail_item;
	res_t       out_item;

	polyev_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	// horner starts from the top coefficient
	assign chain[0] = '{valid: points.valid, x: points.point,
		acc: coefs[MAX_DEGREE], ovf: 1'b0};

	// the whole chain moves together, so a point is taken whenever it moves
	assign points.ready = en;

	// cell k folds in the next lower coefficient
	for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_cell
		polyev_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.coef   (coefs[MAX_DEGREE-1-k]),
			.cin    (chain[k]),
			.cout   (chain[k+1])
		);
	end

	assign tail_item = '{value: chain[MAX_DEGREE].acc, overflow: chain[MAX_DEGREE].ovf};

	polyev_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (chain[MAX_DEGREE].valid),
		.item       (tail_item),
		.en         (en),
		.out_valid  (results.valid),
		.out_item   (out_item),
		.out_ready  (results.ready)
	);

	assign results.value    = out_item.value;
	assign results.overflow = out_item.overflow;

	// a point is only taken while the chain advances
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(points.valid && points.ready) |-> en)
		else $error("point transfer while chain held");

	// a held chain keeps its tail item
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && chain[MAX_DEGREE].valid) |=> chain[MAX_DEGREE].valid)
		else $error("tail item lost during hold");

	// an empty pipeline never shows a result out of nothing
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!results.valid && !chain[MAX_DEGREE].valid) |=> !results.valid)
		else $error("result appeared without a tail item");

endmodule

/* dv/polynomial_evaluator_test.sv */
`timescale 1ns / 1ps
// testbench of the polynomial evaluator: directed and random points checked against a horner scoreboard

module polynomial_evaluator_test;
	import polyev_pkg::*;

	localparam int DEGREE       = 7;
	localparam int PIPE_LAT     = 2 * DEGREE + 1;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_POINTS = 122;
	// long receiver hold-off, taken once when this many results have arrived
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 200;

	localparam q_t ONE  = 32'sh0001_0000;
	localparam q_t HALF = 32'sh0000_8000;

	// coefficient registers in address order
	typedef enum int {
		COEF_0_REG, COEF_1_REG, COEF_2_REG, COEF_3_REG,
		COEF_4_REG, COEF_5_REG, COEF_6_REG, COEF_7_REG
	} coef_reg_e;

	// coefficient copy and the queue of values still owed by the block
	class horner_board;
		q_t   coef_shadow[NUM_COEFS];
		res_t pending_values[$];
		int   mismatches;

		function new();
			foreach (coef_shadow[i]) coef_shadow[i] = '0;
			mismatches = 0;
		endfunction

		function void set_coef(coef_reg_e r, q_t v);
			coef_shadow[r] = v;
		endfunction

		// clamp to 32 bits, overflow flag is sticky across the item
		function q_t clamp_q(input longint v, inout logic ovf);
			if (v > longint'(Q_MAX)) begin
				ovf = 1'b1;
				return Q_MAX;
			end
			if (v < longint'(Q_MIN)) begin
				ovf = 1'b1;
				return Q_MIN;
			end
			return q_t'(v);
		endfunction

		// horner from the top coefficient, product floored by the shift
		function res_t eval_horner(q_t x);
			q_t     acc;
			logic   ovf;
			longint prod;
			int     k;
			res_t   r;
			acc = coef_shadow[DEGREE];
			ovf = 1'b0;
			for (k = DEGREE - 1; k >= 0; k--) begin
				prod = (longint'(acc) * longint'(x)) >>> FRAC_BITS;
				acc  = clamp_q(prod, ovf);
				acc  = clamp_q(longint'(acc) + longint'(coef_shadow[k]), ovf);
			end
			r.value    = acc;
			r.overflow = ovf;
			return r;
		endfunction

		function void note_point(q_t x);
			pending_values = {pending_values, eval_horner(x)};
		endfunction

		function void check_result(q_t value, logic overflow);
			res_t want;
			if (pending_values.size() == 0) begin
				$error("value: expected none, actual %0d", value);
				mismatches++;
				return;
			end
			want = pending_values.pop_front();
			if (value !== want.value) begin
				$error("value: expected %0d, actual %0d", want.value, value);
				mismatches++;
			end
			if (overflow !== want.overflow) begin
				$error("overflow: expected %0b, actual %0b", want.overflow, overflow);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_values.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	polyev_point_if  pts();
	polyev_result_if res();

	horner_board board = new();

	int unsigned cycles = 0;
	int          points_sent = 0;
	int          results_seen = 0;

	polynomial_evaluator #(.MAX_DEGREE(DEGREE)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.points  (pts),
		.results (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// signed value spread evenly over -span .. +span
	function automatic q_t rand_signed(int span);
		return q_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// mostly small points so results stay in range, some wide, a few raw 32-bit
	function automatic q_t rand_point();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return rand_signed(4 * ONE);
		if (r < 9) return rand_signed(64 * ONE);
		return q_t'($urandom);
	endfunction

	// apb write: setup cycle, then access cycle, register lands at the pready edge
	// psel is left high so back-to-back writes need no extra step
	task automatic write_coef(coef_reg_e r, q_t v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(r) << IDX_LSB);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		board.set_coef(r, v);
	endtask

	task automatic load_coefs(q_t c[NUM_COEFS]);
		foreach (c[i]) write_coef(coef_reg_e'(i), c[i]);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// one point transfer; gaps drawn per item, with gap-free stretches
	// valid is only lowered when a gap follows, so it never toggles in one step
	task automatic send_point(q_t x);
		int gap;
		gap = ((points_sent / 40) % 3 == 0) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			pts.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pts.valid <= 1'b1;
		pts.point <= x;
		// ready is stable mid-cycle, so the transfer happens at the next edge
		do @(negedge clk); while (!pts.ready);
		@(posedge clk);
		board.note_point(x);
		points_sent++;
	endtask

	task automatic send_list(q_t xs[$]);
		foreach (xs[i]) send_point(xs[i]);
	endtask

	// block idle again: nothing in flight, every value delivered
	task automatic drain();
		pts.valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	// coefficient sets for the random phases
	task automatic pick_coefs(output q_t c[NUM_COEFS], input int style);
		int top;
		case (style)
			0: begin
				// magnitudes up to two, mild growth
				foreach (c[i]) c[i] = rand_signed(2 * ONE);
			end
			1: begin
				// full range, saturation on most steps
				foreach (c[i]) c[i] = q_t'($urandom);
			end
			default: begin
				// random degree, unused high terms cleared, one term maybe at a limit
				top = $urandom_range(1, DEGREE);
				foreach (c[i]) c[i] = (i <= top) ? rand_signed(4 * ONE) : '0;
				if ($urandom_range(0, 1)) c[$urandom_range(0, top)] =
					$urandom_range(0, 1) ? Q_MAX : Q_MIN;
			end
		endcase
	endtask

	// result side: random stalls, gap-free stretches, one long hold-off
	initial begin
		int   stall;
		bit   held;
		q_t   v;
		logic o;
		held = 1'b0;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && results_seen == HOLD_AT) begin
				// points keep coming, so the chain fills and stalls its input
				held  = 1'b1;
				stall = HOLD_CYCLES;
			end else begin
				stall = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 7);
			end
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(negedge clk); while (!res.valid);
			v = res.value;
			o = res.overflow;
			@(posedge clk);
			board.check_result(v, o);
			results_seen++;
		end
	end

	// stimulus
	initial begin
		q_t c[NUM_COEFS];
		int ph;
		int n;

		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		pts.valid <= 1'b0;
		pts.point <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficients at reset: everything evaluates to zero
		send_list('{q_t'(0), Q_MAX, Q_MIN});
		drain();

		// all coefficients at the positive limit: sum and product saturation
		foreach (c[i]) c[i] = Q_MAX;
		load_coefs(c);
		send_list('{q_t'(0), ONE, -ONE, Q_MAX, Q_MIN});
		drain();

		// all coefficients at the negative limit
		foreach (c[i]) c[i] = Q_MIN;
		load_coefs(c);
		send_list('{Q_MIN, ONE, -ONE, HALF});
		drain();

		// small quadratic, floor of negative products at one lsb
		c = '{ONE, -2 * ONE, HALF, 0, 0, 0, 0, 0};
		load_coefs(c);
		send_list('{2 * ONE, -(3 * ONE + HALF), q_t'(-1), q_t'(1), q_t'(32'sh7fff)});
		drain();

		// pure x^7: products run out of range for large x
		c = '{0, 0, 0, 0, 0, 0, 0, ONE};
		load_coefs(c);
		send_list('{2 * ONE, 32 * ONE, -32 * ONE, q_t'(-1)});
		drain();

		// random phases, new coefficients between them while idle
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			pick_coefs(c, ph % 3);
			load_coefs(c);
			for (n = 0; n < PHASE_POINTS; n++) send_point(rand_point());
			drain();
		end

		repeat (PIPE_LAT + 5) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
